// ===== hw/rtl/bvm_pkg.sv =====
package bvm_pkg;

  // Field and register widths
  localparam int SAMPLE_W        = 10;
  localparam int POWER_W         = 1;
  localparam int VOLT_W          = 8;
  localparam int DOWN_LIMIT_W    = 8;
  localparam int DELTA_LIMIT_W   = 10;
  localparam int DIVIDER_W       = 10;
  localparam int DIVIDER_SUM_W   = DIVIDER_W + 1;
  localparam int CFG_DATA_W      = 10;
  localparam int CFG_IDX_W       = 2;

  // Ring geometry
  localparam int RING_DEPTH      = 8;
  localparam int RING_IDX_W      = $clog2(RING_DEPTH);
  localparam int REFILL_W        = $clog2(RING_DEPTH + 1);

  // Scale factor of the conversion (times 33 is shift by 5 plus one)
  localparam int SCALE_SHIFT     = 5;
  localparam int SCALE_W         = SCALE_SHIFT + 1;

  localparam int SAMPLE_BITS_DEF = 10;

  // Register reset values
  localparam logic [DOWN_LIMIT_W-1:0]  DOWN_LIMIT_RST     = 8'd0;
  localparam logic [DELTA_LIMIT_W-1:0] DELTA_LIMIT_RST    = 10'd50;
  localparam logic [DIVIDER_W-1:0]     DIVIDER_TOP_RST    = 10'd402;
  localparam logic [DIVIDER_W-1:0]     DIVIDER_BOTTOM_RST = 10'd100;

  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOWN_LIMIT     = 2'd0,
    REG_DELTA_LIMIT    = 2'd1,
    REG_DIVIDER_TOP    = 2'd2,
    REG_DIVIDER_BOTTOM = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } bvm_state_t;

  // Ring update outcome toward the sequencer
  typedef struct packed {
    logic emit;
    logic refill;
  } ring_stat_t;

endpackage

// ===== hw/rtl/bvm_if.sv =====
interface bvm_in_if;
  import bvm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                power_on;

  modport source (output valid, output sample, output power_on, input ready);
  modport sink   (input valid, input sample, input power_on, output ready);
endinterface

interface bvm_out_if;
  import bvm_pkg::*;

  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage;
  logic              shutoff;

  modport source (output valid, output voltage, output shutoff, input ready);
  modport sink   (input valid, input voltage, input shutoff, output ready);
endinterface

// ===== hw/rtl/bvm_div.sv =====
module bvm_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);
  import bvm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider not busy after start");

endmodule

// ===== hw/rtl/bvm_ring.sv =====
module bvm_ring #(
  parameter int SAMPLE_BITS = bvm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [SAMPLE_BITS-1:0]              smp,
  input  logic [bvm_pkg::DELTA_LIMIT_W-1:0]   delta_limit,
  output bvm_pkg::ring_stat_t                 stat,
  output logic [SAMPLE_BITS+bvm_pkg::RING_IDX_W-1:0] sum
);
  import bvm_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + RING_IDX_W;
  localparam int CMP_W = (SAMPLE_BITS > DELTA_LIMIT_W) ? SAMPLE_BITS : DELTA_LIMIT_W;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [SUM_W-1:0]       running_sum;
  logic [RING_IDX_W-1:0]  ring_index;
  logic [REFILL_W-1:0]    refill_left;

  logic [RING_IDX_W-1:0]  idx_inc;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] jump;
  logic                   refilling;
  logic                   too_far;

  assign idx_inc   = ring_index + 1'b1;
  assign refilling = (refill_left != '0);

  // Distance of the new sample from the current average
  assign avg     = running_sum[SUM_W-1:RING_IDX_W];
  assign jump    = (smp > avg) ? (smp - avg) : (avg - smp);
  assign too_far = (CMP_W'(jump) > CMP_W'(delta_limit));

  // Ring update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
      running_sum <= '0;
      ring_index  <= '0;
      refill_left <= '0;
    end else if (take) begin
      if (refilling) begin
        ring[ring_index] <= smp;
        running_sum      <= running_sum + SUM_W'(smp);
        ring_index       <= idx_inc;
        refill_left      <= refill_left - 1'b1;
      end else if (too_far) begin
        // drop the sample and restart the fill from entry zero
        running_sum <= '0;
        ring_index  <= '0;
        refill_left <= REFILL_W'(RING_DEPTH);
      end else begin
        ring[idx_inc] <= smp;
        running_sum   <= running_sum - SUM_W'(ring[idx_inc]) + SUM_W'(smp);
        ring_index    <= idx_inc;
      end
    end
  end

  // Result follows a normal update or the last sample of a refill
  always_comb begin
    stat.refill = refilling;
    if (refilling) begin
      stat.emit = (refill_left == REFILL_W'(1));
    end else begin
      stat.emit = !too_far;
    end
  end

  assign sum = running_sum;

  a_refill_range: assert property (@(posedge clk) disable iff (rst)
    take && !refilling && too_far |=> refill_left == REFILL_W'(RING_DEPTH))
    else $error("refill not started after jump");

endmodule

// ===== hw/rtl/battery_voltage_monitor.sv =====
// Channel  Role    Payload                       Handshake
// adc      sink    sample[9:0], power_on         valid/ready
// result   source  voltage[7:0], shutoff         valid/ready
// cfg      write   cfg_idx[1:0], cfg_data[9:0]   cfg_we
//
// A result reaches the output register through the multiply, the divider load,
// 17 divider steps, the divider exit and the load; the next transaction is taken
// once the sequencer is idle again; an item with no result leaves it idle.
// Reset (rst, synchronous) clears the ring, sum, registers and handshakes.
// A result waiting in the output register does not stop acceptance; the
// sequencer holds the next result until that register is free.
module battery_voltage_monitor #(
  parameter int SAMPLE_BITS = bvm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  bvm_in_if.sink                          adc,
  bvm_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bvm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bvm_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + RING_IDX_W;
  localparam int PROD_W = SUM_W + DIVIDER_SUM_W;
  localparam int P33_W  = PROD_W + SCALE_W;
  localparam int NUM_W  = P33_W - SUM_W;

  // Configuration registers
  logic [DOWN_LIMIT_W-1:0]  down_limit;
  logic [DELTA_LIMIT_W-1:0] delta_limit;
  logic [DIVIDER_W-1:0]     divider_top;
  logic [DIVIDER_W-1:0]     divider_bottom;

  bvm_state_t state, state_next;

  ring_stat_t         ring_stat;
  logic [SUM_W-1:0]   sum;
  logic               take;
  logic               power;
  logic [PROD_W-1:0]  prod;
  logic [P33_W-1:0]   prod33;
  logic               prod_load;
  logic               div_start;
  logic               div_busy;
  logic [NUM_W-1:0]   quotient;
  logic               out_load;
  logic [VOLT_W-1:0]  volt;

  logic               res_valid;
  logic [VOLT_W-1:0]  res_voltage;
  logic               res_shutoff;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      down_limit     <= DOWN_LIMIT_RST;
      delta_limit    <= DELTA_LIMIT_RST;
      divider_top    <= DIVIDER_TOP_RST;
      divider_bottom <= DIVIDER_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_DOWN_LIMIT:     down_limit     <= cfg_data[DOWN_LIMIT_W-1:0];
        REG_DELTA_LIMIT:    delta_limit    <= cfg_data[DELTA_LIMIT_W-1:0];
        REG_DIVIDER_TOP:    divider_top    <= cfg_data[DIVIDER_W-1:0];
        REG_DIVIDER_BOTTOM: divider_bottom <= cfg_data[DIVIDER_W-1:0];
        default: ;
      endcase
    end
  end

  assign adc.ready = (state == ST_IDLE);
  assign take      = adc.valid && adc.ready;

  bvm_ring #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .smp         (SAMPLE_BITS'(adc.sample)),
    .delta_limit (delta_limit),
    .stat        (ring_stat),
    .sum         (sum)
  );

  // Hold power flag of the accepted transaction
  always_ff @(posedge clk) begin
    if (take) begin
      power <= adc.power_on;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take && ring_stat.emit) state_next = ST_MUL;
      ST_MUL:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (!div_busy) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    prod_load = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_MUL:   prod_load = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DONE:  out_load  = !res_valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sum * (top + bottom), times 33 as shift and add
  always_ff @(posedge clk) begin
    if (prod_load) begin
      prod <= PROD_W'(sum) * PROD_W'(DIVIDER_SUM_W'(divider_top) +
                                     DIVIDER_SUM_W'(divider_bottom));
    end
  end

  assign prod33 = (P33_W'(prod) << SCALE_SHIFT) + P33_W'(prod);

  // Dividing by 2^SUM_W first leaves the quotient by bottom unchanged
  bvm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIVIDER_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod33[P33_W-1:SUM_W]),
    .divisor  (divider_bottom),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Saturate
  always_comb begin
    if (divider_bottom == '0 || quotient[NUM_W-1:VOLT_W] != '0) begin
      volt = VOLT_MAX;
    end else begin
      volt = quotient[VOLT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_voltage <= volt;
      res_shutoff <= power && (down_limit != '0) &&
                     (DOWN_LIMIT_W'(volt) < down_limit);
    end
  end

  assign result.valid   = res_valid;
  assign result.voltage = res_voltage;
  assign result.shutoff = res_shutoff;

  a_ready_div: assert property (@(posedge clk) disable iff (rst)
    adc.ready |-> !div_busy)
    else $error("input ready while divider busy");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside load state");

  a_zero_bottom: assert property (@(posedge clk) disable iff (rst)
    out_load && divider_bottom == '0 |=> result.voltage == VOLT_MAX)
    else $error("zero bottom resistor not saturated");

  a_refill_idle: assert property (@(posedge clk) disable iff (rst)
    take && ring_stat.refill && !ring_stat.emit |=> state == ST_IDLE)
    else $error("refill transaction left the idle state");

endmodule
